### rtl/core/krst_pkg.sv
// krst_pkg: shared types, codes and helpers for the keyed record slot table
// used by krst_ctrl, krst_dp and keyed_record_slot_table_unit; no dependencies
`default_nettype none

package krst_pkg;

  localparam int TABLE_SLOTS_DEF = 16;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 14;
  localparam int CODE_W   = 3;
  localparam int AGE_W    = 7;
  localparam int STATUS_W = 3;
  localparam int SIDX_W   = 4;

  localparam logic [CODE_W-1:0] CODE_MAX = 3'd5;
  localparam logic [AGE_W-1:0]  AGE_MAX  = 7'd99;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_TYP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_VAC = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ANY     = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BADFIELD = 3'd4;

  // stored record, 14 bits: type, color, age, vaccinated
  typedef struct packed {
    logic [CODE_W-1:0] rtype;
    logic [CODE_W-1:0] color;
    logic [AGE_W-1:0]  age;
    logic              vac;
  } rec_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic commit;
  } dp_cmd_t;

  function automatic logic code_ok(input logic [CODE_W-1:0] c);
    code_ok = (c >= 3'd1) && (c <= CODE_MAX);
  endfunction

  function automatic logic age_ok(input logic [AGE_W-1:0] a);
    age_ok = (a >= 7'd1) && (a <= AGE_MAX);
  endfunction

endpackage

`default_nettype wire

### rtl/core/krst_ctrl.sv
// krst_ctrl: two-state sequencer plus output register occupancy
// depends on krst_pkg for state_t and dp_cmd_t
`default_nettype none

module krst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output krst_pkg::dp_cmd_t    dp_cmd
);

  krst_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    dp_cmd.load_in = 1'b0;
    dp_cmd.commit  = 1'b0;
    case (state_r)
      krst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = krst_pkg::ST_EXEC;
        end
      end
      krst_pkg::ST_EXEC: begin
        // result register must be empty or draining this cycle
        if (!out_valid_r || !out_stall) begin
          dp_cmd.commit = 1'b1;
          state_nxt     = krst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = krst_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (dp_cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/core/krst_dp.sv
// krst_dp: slot registers, parallel key compare, first-free encoder, result register
// depends on krst_pkg for field widths, codes and rec_t
`default_nettype none

module krst_dp #(
  parameter int TABLE_SLOTS = krst_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire krst_pkg::dp_cmd_t                dp_cmd,
  input  wire logic [krst_pkg::CMD_W-1:0]       in_command,
  input  wire logic [krst_pkg::KEY_W-1:0]       in_record_id,
  input  wire logic [krst_pkg::CODE_W-1:0]      in_type_code,
  input  wire logic [krst_pkg::CODE_W-1:0]      in_color_code,
  input  wire logic [krst_pkg::AGE_W-1:0]       in_age_years,
  input  wire logic                             in_vaccinated_flag,
  output logic [krst_pkg::STATUS_W-1:0]         out_status,
  output logic [krst_pkg::SIDX_W-1:0]           out_slot_index,
  output logic [krst_pkg::CODE_W-1:0]           out_found_type,
  output logic [krst_pkg::CODE_W-1:0]           out_found_color,
  output logic [krst_pkg::AGE_W-1:0]            out_found_age,
  output logic                                  out_found_vaccinated,
  output logic                                  out_any_occupied
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // captured command
  logic [krst_pkg::CMD_W-1:0]  cmd_r;
  logic [krst_pkg::KEY_W-1:0]  key_r;
  krst_pkg::rec_t              rec_r;

  // slot table
  logic [TABLE_SLOTS-1:0]      slot_valid_r, slot_valid_nxt;
  logic [krst_pkg::KEY_W-1:0]  slot_key_r [TABLE_SLOTS];
  krst_pkg::rec_t              slot_fields_r [TABLE_SLOTS];

  // result register
  logic [krst_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [krst_pkg::SIDX_W-1:0]   sidx_r, sidx_nxt;
  krst_pkg::rec_t                res_r, res_nxt;
  logic                          any_r, any_nxt;

  logic             match_found, free_found;
  logic [IDX_W-1:0] match_idx, free_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  krst_pkg::rec_t   wr_rec;
  krst_pkg::rec_t   match_rec;
  logic             fields_ok;

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_r       <= in_command;
      key_r       <= in_record_id;
      rec_r.rtype <= in_type_code;
      rec_r.color <= in_color_code;
      rec_r.age   <= in_age_years;
      rec_r.vac   <= in_vaccinated_flag;
    end
  end

  // parallel compare and first-free search, lowest slot wins
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && (slot_key_r[i] == key_r)) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(i);
      end
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign match_rec = slot_fields_r[match_idx];
  assign fields_ok = krst_pkg::code_ok(rec_r.rtype) && krst_pkg::code_ok(rec_r.color) &&
                     krst_pkg::age_ok(rec_r.age);

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    wr_en          = 1'b0;
    wr_idx         = match_idx;
    wr_rec         = match_rec;
    status_nxt     = krst_pkg::STAT_OK;
    sidx_nxt       = '0;
    res_nxt        = '0;
    case (cmd_r)
      krst_pkg::CMD_INSERT: begin
        if (!free_found) begin
          status_nxt = krst_pkg::STAT_FULL;
        end else if (match_found) begin
          status_nxt = krst_pkg::STAT_DUP;
        end else if (!fields_ok) begin
          status_nxt = krst_pkg::STAT_BADFIELD;
        end else begin
          wr_en                    = 1'b1;
          wr_idx                   = free_idx;
          wr_rec                   = rec_r;
          slot_valid_nxt[free_idx] = 1'b1;
          sidx_nxt                 = krst_pkg::SIDX_W'(free_idx);
          res_nxt                  = rec_r;
        end
      end
      krst_pkg::CMD_REMOVE, krst_pkg::CMD_SET_TYP, krst_pkg::CMD_SET_VAC,
      krst_pkg::CMD_LOOKUP: begin
        if (!match_found) begin
          status_nxt = krst_pkg::STAT_NOTFOUND;
        end else if ((cmd_r == krst_pkg::CMD_SET_TYP) && !krst_pkg::code_ok(rec_r.rtype)) begin
          status_nxt = krst_pkg::STAT_BADFIELD;
        end else begin
          if (cmd_r == krst_pkg::CMD_REMOVE) begin
            slot_valid_nxt[match_idx] = 1'b0;
          end else if (cmd_r == krst_pkg::CMD_SET_TYP) begin
            wr_en        = 1'b1;
            wr_rec.rtype = rec_r.rtype;
          end else if (cmd_r == krst_pkg::CMD_SET_VAC) begin
            wr_en      = 1'b1;
            wr_rec.vac = rec_r.vac;
          end
          // result carries the record as it stands after the command
          sidx_nxt = krst_pkg::SIDX_W'(match_idx);
          res_nxt  = wr_rec;
        end
      end
      krst_pkg::CMD_ANY: begin
        status_nxt = krst_pkg::STAT_OK;
      end
      default: begin
        status_nxt = krst_pkg::STAT_BADFIELD;
      end
    endcase
    any_nxt = |slot_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (dp_cmd.commit) begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit && wr_en) begin
      slot_key_r[wr_idx]    <= key_r;
      slot_fields_r[wr_idx] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      status_r <= status_nxt;
      sidx_r   <= sidx_nxt;
      res_r    <= res_nxt;
      any_r    <= any_nxt;
    end
  end

  assign out_status           = status_r;
  assign out_slot_index       = sidx_r;
  assign out_found_type       = res_r.rtype;
  assign out_found_color      = res_r.color;
  assign out_found_age        = res_r.age;
  assign out_found_vaccinated = res_r.vac;
  assign out_any_occupied     = any_r;

endmodule

`default_nettype wire

### rtl/core/keyed_record_slot_table_unit.sv
// keyed_record_slot_table_unit: top level, joins sequencer and slot datapath
// depends on krst_pkg, krst_ctrl and krst_dp
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  command, record_id, type, color, age, vaccinated
//   out_     output     out_valid/out_stall  status, slot_index, found_*, any_occupied
//
// every item passes two steps: capture, then key compare + first-free search + write-back
// one item at a time; the result register lets the next item be captured while
// the previous result waits, and write-back waits while that register is still full
// reset clears all slot valid bits at once, no clearing pass; table usable right after
// out_stall holds the result register; in_stall is high during write-back
`default_nettype none

module keyed_record_slot_table_unit #(
  parameter int TABLE_SLOTS = krst_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [krst_pkg::CMD_W-1:0]   in_command,
  input  wire logic [krst_pkg::KEY_W-1:0]   in_record_id,
  input  wire logic [krst_pkg::CODE_W-1:0]  in_type_code,
  input  wire logic [krst_pkg::CODE_W-1:0]  in_color_code,
  input  wire logic [krst_pkg::AGE_W-1:0]   in_age_years,
  input  wire logic                         in_vaccinated_flag,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [krst_pkg::STATUS_W-1:0]     out_status,
  output logic [krst_pkg::SIDX_W-1:0]       out_slot_index,
  output logic [krst_pkg::CODE_W-1:0]       out_found_type,
  output logic [krst_pkg::CODE_W-1:0]       out_found_color,
  output logic [krst_pkg::AGE_W-1:0]        out_found_age,
  output logic                              out_found_vaccinated,
  output logic                              out_any_occupied
);

  krst_pkg::dp_cmd_t dp_cmd;

  krst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  krst_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .dp_cmd               (dp_cmd),
    .in_command           (in_command),
    .in_record_id         (in_record_id),
    .in_type_code         (in_type_code),
    .in_color_code        (in_color_code),
    .in_age_years         (in_age_years),
    .in_vaccinated_flag   (in_vaccinated_flag),
    .out_status           (out_status),
    .out_slot_index       (out_slot_index),
    .out_found_type       (out_found_type),
    .out_found_color      (out_found_color),
    .out_found_age        (out_found_age),
    .out_found_vaccinated (out_found_vaccinated),
    .out_any_occupied     (out_any_occupied)
  );

endmodule

`default_nettype wire

### tb/keyed_record_table_checker.sv
// keyed_record_table_checker: watches both channels of the slot table, keeps its own copy
// of the table, predicts each reply and compares it field by field; needs krst_pkg
`timescale 1ns / 1ps

module keyed_record_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [krst_pkg::CMD_W-1:0]      in_command,
  input  logic [krst_pkg::KEY_W-1:0]      in_record_id,
  input  logic [krst_pkg::CODE_W-1:0]     in_type_code,
  input  logic [krst_pkg::CODE_W-1:0]     in_color_code,
  input  logic [krst_pkg::AGE_W-1:0]      in_age_years,
  input  logic                            in_vaccinated_flag,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [krst_pkg::STATUS_W-1:0]   out_status,
  input  logic [krst_pkg::SIDX_W-1:0]     out_slot_index,
  input  logic [krst_pkg::CODE_W-1:0]     out_found_type,
  input  logic [krst_pkg::CODE_W-1:0]     out_found_color,
  input  logic [krst_pkg::AGE_W-1:0]      out_found_age,
  input  logic                            out_found_vaccinated,
  input  logic                            out_any_occupied,
  output int                              fail_count,
  output int                              replies_pending
);
  import krst_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIDX_W-1:0]   slot;
    rec_t                rec;
    logic                any;
  } reply_t;

  logic                slot_used [SLOTS];
  logic [KEY_W-1:0]    slot_id   [SLOTS];
  rec_t                slot_rec  [SLOTS];
  reply_t              replies_due [$];

  initial begin
    fail_count = 0;
    replies_pending = 0;
  end

  function automatic logic code_in_range(input logic [CODE_W-1:0] c);
    return (c != '0) && (c <= CODE_MAX);
  endfunction

  // applies one command to the local table and returns the reply it must give
  function automatic reply_t predict_table_reply(
    input logic [CMD_W-1:0]  cmd,
    input logic [KEY_W-1:0]  id,
    input logic [CODE_W-1:0] typ,
    input logic [CODE_W-1:0] col,
    input logic [AGE_W-1:0]  age,
    input logic              vac
  );
    reply_t r;
    int     hit;
    int     free_slot;
    int     sel;
    r = '0;
    hit = -1;
    free_slot = -1;
    sel = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_id[i] == id) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (free_slot < 0) r.status = STAT_FULL;
        else if (hit >= 0) r.status = STAT_DUP;
        else if (!code_in_range(typ) || !code_in_range(col) || age == '0 || age > AGE_MAX)
          r.status = STAT_BADFIELD;
        else begin
          slot_used[free_slot] = 1'b1;
          slot_id[free_slot] = id;
          slot_rec[free_slot] = '{rtype: typ, color: col, age: age, vac: vac};
          sel = free_slot;
        end
      end
      CMD_REMOVE, CMD_SET_TYP, CMD_SET_VAC, CMD_LOOKUP: begin
        if (hit < 0) r.status = STAT_NOTFOUND;
        else begin
          sel = hit;
          if (cmd == CMD_REMOVE) slot_used[hit] = 1'b0;
          else if (cmd == CMD_SET_TYP) begin
            if (code_in_range(typ)) slot_rec[hit].rtype = typ;
            else begin
              r.status = STAT_BADFIELD;
              sel = -1;
            end
          end else if (cmd == CMD_SET_VAC) slot_rec[hit].vac = vac;
        end
      end
      CMD_ANY: ;
      default: r.status = STAT_BADFIELD;
    endcase
    if (sel >= 0) begin
      r.slot = sel[SIDX_W-1:0];
      r.rec = slot_rec[sel];
    end
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i]) r.any = 1'b1;
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t due;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      replies_due.delete();
    end else begin
      // the reply leaving now always belongs to an earlier item
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none expected, actual status %0d", $time, out_status);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          check_field("status", int'(due.status), int'(out_status));
          check_field("slot_index", int'(due.slot), int'(out_slot_index));
          check_field("found_type", int'(due.rec.rtype), int'(out_found_type));
          check_field("found_color", int'(due.rec.color), int'(out_found_color));
          check_field("found_age", int'(due.rec.age), int'(out_found_age));
          check_field("found_vaccinated", int'(due.rec.vac), int'(out_found_vaccinated));
          check_field("any_occupied", int'(due.any), int'(out_any_occupied));
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(predict_table_reply(in_command, in_record_id, in_type_code,
                                                  in_color_code, in_age_years,
                                                  in_vaccinated_flag));
    end
    replies_pending = replies_due.size();
  end

endmodule

### tb/keyed_record_slot_table_unit_tb.sv
// keyed_record_slot_table_unit_tb: drives directed and random record commands into the
// slot table with random idling and one long output hold; needs krst_pkg and the checker
`timescale 1ns / 1ps

module keyed_record_slot_table_unit_tb;
  import krst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 850;
  localparam int KEY_POOL = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT_ITEM = 200;
  localparam int HOLD_CYCLES = 80;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command = CMD_ANY;
  logic [KEY_W-1:0]    in_record_id = '0;
  logic [CODE_W-1:0]   in_type_code = '0;
  logic [CODE_W-1:0]   in_color_code = '0;
  logic [AGE_W-1:0]    in_age_years = '0;
  logic                in_vaccinated_flag = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SIDX_W-1:0]   out_slot_index;
  logic [CODE_W-1:0]   out_found_type;
  logic [CODE_W-1:0]   out_found_color;
  logic [AGE_W-1:0]    out_found_age;
  logic                out_found_vaccinated;
  logic                out_any_occupied;

  int                  fail_count;
  int                  replies_pending;
  int                  items_sent = 0;
  int unsigned         cycle_count = 0;
  int                  hold_left = 0;
  logic                hold_done = 1'b0;
  logic                steady = 1'b0;

  always #10 clk = ~clk;

  keyed_record_slot_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_record_id(in_record_id),
    .in_type_code(in_type_code), .in_color_code(in_color_code),
    .in_age_years(in_age_years), .in_vaccinated_flag(in_vaccinated_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot_index(out_slot_index),
    .out_found_type(out_found_type), .out_found_color(out_found_color),
    .out_found_age(out_found_age), .out_found_vaccinated(out_found_vaccinated),
    .out_any_occupied(out_any_occupied)
  );

  keyed_record_table_checker table_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_record_id(in_record_id),
    .in_type_code(in_type_code), .in_color_code(in_color_code),
    .in_age_years(in_age_years), .in_vaccinated_flag(in_vaccinated_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot_index(out_slot_index),
    .out_found_type(out_found_type), .out_found_color(out_found_color),
    .out_found_age(out_found_age), .out_found_vaccinated(out_found_vaccinated),
    .out_any_occupied(out_any_occupied),
    .fail_count(fail_count), .replies_pending(replies_pending)
  );

  // receiver: random stalls, one long hold once enough items went in
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] id,
                               input logic [CODE_W-1:0] typ, input logic [CODE_W-1:0] col,
                               input logic [AGE_W-1:0] age, input logic vac);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_record_id <= id;
    in_type_code <= typ;
    in_color_code <= col;
    in_age_years <= age;
    in_vaccinated_flag <= vac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input logic filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
    if (r < 8) return CMD_ANY;
    if (r < 20) return CMD_LOOKUP;
    if (r < 30) return CMD_SET_TYP;
    if (r < 40) return CMD_SET_VAC;
    if (filling) return (r < 85) ? CMD_INSERT : CMD_REMOVE;
    return (r < 55) ? CMD_INSERT : CMD_REMOVE;
  endfunction

  initial begin
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [KEY_W-1:0] id;
    logic [CODE_W-1:0] typ;
    logic [CODE_W-1:0] col;
    logic [AGE_W-1:0] age;
    for (int k = 0; k < KEY_POOL; k++) key_pool[k] = KEY_W'($urandom_range(0, 16383));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, not-found ahead of bad type
    offer_command(CMD_ANY,     14'd0,     3'd0, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_LOOKUP,  14'd0,     3'd1, 3'd1, 7'd1,   1'b0);
    offer_command(CMD_REMOVE,  14'd5,     3'd1, 3'd1, 7'd1,   1'b0);
    offer_command(CMD_SET_TYP, 14'd5,     3'd0, 3'd1, 7'd1,   1'b0);
    // field extremes, then duplicate ahead of bad field
    offer_command(CMD_INSERT,  14'd0,     3'd1, 3'd1, 7'd1,   1'b0);
    offer_command(CMD_INSERT,  14'd16383, 3'd5, 3'd5, 7'd99,  1'b1);
    offer_command(CMD_INSERT,  14'd0,     3'd0, 3'd7, 7'd127, 1'b1);
    offer_command(CMD_INSERT,  14'd100,   3'd0, 3'd3, 7'd10,  1'b0);
    offer_command(CMD_INSERT,  14'd100,   3'd6, 3'd3, 7'd10,  1'b0);
    offer_command(CMD_INSERT,  14'd100,   3'd7, 3'd3, 7'd10,  1'b1);
    offer_command(CMD_INSERT,  14'd100,   3'd2, 3'd0, 7'd10,  1'b0);
    offer_command(CMD_INSERT,  14'd100,   3'd2, 3'd7, 7'd10,  1'b0);
    offer_command(CMD_INSERT,  14'd100,   3'd2, 3'd3, 7'd0,   1'b0);
    offer_command(CMD_INSERT,  14'd100,   3'd2, 3'd3, 7'd100, 1'b0);
    offer_command(CMD_INSERT,  14'd100,   3'd2, 3'd3, 7'd127, 1'b1);
    offer_command(CMD_LOOKUP,  14'd16383, 3'd0, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_SET_TYP, 14'd0,     3'd5, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_SET_TYP, 14'd0,     3'd0, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_SET_TYP, 14'd0,     3'd7, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_SET_VAC, 14'd0,     3'd0, 3'd0, 7'd0,   1'b1);
    offer_command(CMD_SET_VAC, 14'd16383, 3'd0, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_SPARE_LO, 14'd0,    3'd1, 3'd1, 7'd1,   1'b0);
    offer_command(CMD_SPARE_HI, 14'd16383, 3'd1, 3'd1, 7'd1,  1'b1);
    // removal frees the slot but still returns the record
    offer_command(CMD_REMOVE,  14'd0,     3'd0, 3'd0, 7'd0,   1'b0);
    offer_command(CMD_LOOKUP,  14'd0,     3'd0, 3'd0, 7'd0,   1'b0);

    // alternating fill and drain phases over a small key set so the table goes full
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 550);
      if ($urandom_range(0, 99) < 10) id = KEY_W'($urandom_range(0, 16383));
      else id = key_pool[$urandom_range(0, KEY_POOL - 1)];
      if ($urandom_range(0, 99) < 85) begin
        typ = CODE_W'($urandom_range(1, 5));
        col = CODE_W'($urandom_range(1, 5));
        age = AGE_W'($urandom_range(1, 99));
      end else begin
        typ = CODE_W'($urandom_range(0, 7));
        col = CODE_W'($urandom_range(0, 7));
        age = AGE_W'($urandom_range(0, 127));
      end
      offer_command(pick_command(((n / 100) % 2) == 0), id, typ, col, age,
                    1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // let the checker record the last accepted item before waiting on the queue
    @(posedge clk);
    wait (replies_pending == 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
